// ===== hw/rtl/wpp_pkg.sv =====
// Shared types, codes and constants for the WAV PCM stream parser.
`timescale 1ns / 1ps
`default_nettype none
package wpp_pkg;

    localparam int MAX_SAMPLE_BYTES_DEF = 8;
    localparam int STREAM_LEN_W         = 33;
    localparam int TDATA_W              = 216;

    localparam logic [31:0] TAG_RIFF = 32'h4646_4952;
    localparam logic [31:0] TAG_WAVE = 32'h4556_4157;
    localparam logic [31:0] TAG_FMT  = 32'h2074_6D66;
    localparam logic [31:0] TAG_DATA = 32'h6174_6164;

    localparam logic [1:0] KIND_SAMPLE = 2'd0;
    localparam logic [1:0] KIND_FORMAT = 2'd1;
    localparam logic [1:0] KIND_ERROR  = 2'd2;

    localparam logic [3:0] ERR_RIFF_TAG    = 4'd0;
    localparam logic [3:0] ERR_WAVE_TAG    = 4'd1;
    localparam logic [3:0] ERR_SIZE        = 4'd2;
    localparam logic [3:0] ERR_NOT_PCM     = 4'd3;
    localparam logic [3:0] ERR_ZERO_CHAN   = 4'd4;
    localparam logic [3:0] ERR_ZERO_ALIGN  = 4'd5;
    localparam logic [3:0] ERR_BITS_LOW    = 4'd6;
    localparam logic [3:0] ERR_BITS_HIGH   = 4'd7;
    localparam logic [3:0] ERR_ALIGN       = 4'd8;
    localparam logic [3:0] ERR_DATA_EARLY  = 4'd9;
    localparam logic [3:0] ERR_DATA_SIZE   = 4'd10;
    localparam logic [3:0] ERR_EARLY_END   = 4'd11;

    typedef enum logic [6:0] {
        PH_RIFF    = 7'b0000001,
        PH_CHUNK   = 7'b0000010,
        PH_FMT     = 7'b0000100,
        PH_SKIP    = 7'b0001000,
        PH_SAMPLES = 7'b0010000,
        PH_DONE    = 7'b0100000,
        PH_ERROR   = 7'b1000000
    } phase_t;

    typedef struct packed {
        logic [1:0]  kind;
        logic [63:0] sample;
        logic [15:0] chan;
        logic        fend;
        logic [3:0]  err;
        logic [15:0] chan_count;
        logic [31:0] rate;
        logic [31:0] byte_rate;
        logic [15:0] bits;
        logic [31:0] frames;
        logic        run_end;
    } res_t;

    typedef struct packed {
        logic latch;
        logic div_start;
        logic apply;
        logic sel;
    } cmd_t;

    typedef struct packed {
        logic       need_div;
        logic       div_done;
        logic [1:0] step_rows;
        logic       two_rows;
    } sts_t;

endpackage
`default_nettype wire

// ===== hw/rtl/wpp_div.sv =====
// Radix-2 restoring divider, 32-bit dividend by 16-bit divisor.
`timescale 1ns / 1ps
`default_nettype none
module wpp_div (
    input  wire         aclk,
    input  wire         aresetn,
    input  wire         start,
    input  wire  [31:0] dividend,
    input  wire  [15:0] divisor,
    output logic        done,
    output logic [31:0] quotient,
    output logic [15:0] remainder
);
    logic [15:0] rem_reg, rem_next;
    logic [31:0] quo_reg, quo_next;
    logic [15:0] dvs_reg;
    logic [4:0]  cnt_reg;
    logic        busy_reg;
    logic        done_reg;
    logic [16:0] trial;
    logic [16:0] diff;
    logic        ge;

    always_comb begin
        trial    = {rem_reg, quo_reg[31]};
        diff     = trial - {1'b0, dvs_reg};
        ge       = trial >= {1'b0, dvs_reg};
        rem_next = ge ? diff[15:0] : trial[15:0];
        quo_next = {quo_reg[30:0], ge};
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end else if (busy_reg) begin
                cnt_reg <= cnt_reg + 5'd1;
                if (cnt_reg == 5'd31) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (start) begin
            rem_reg <= '0;
            quo_reg <= dividend;
            dvs_reg <= divisor;
        end else if (busy_reg) begin
            rem_reg <= rem_next;
            quo_reg <= quo_next;
        end
    end

    assign done      = done_reg;
    assign quotient  = quo_reg;
    assign remainder = rem_reg;
endmodule
`default_nettype wire

// ===== hw/rtl/wpp_ctrl.sv =====
// Sequencing controller: byte request, divide wait, apply and result delivery.
`timescale 1ns / 1ps
`default_nettype none
module wpp_ctrl (
    input  wire            aclk,
    input  wire            aresetn,
    input  wire            s_tvalid,
    output logic           s_tready,
    output logic           m_tvalid,
    input  wire            m_tready,
    input  wpp_pkg::sts_t  sts,
    output wpp_pkg::cmd_t  cmd
);
    import wpp_pkg::*;

    typedef enum logic [5:0] {
        ST_IDLE  = 6'b000001,
        ST_CHECK = 6'b000010,
        ST_DIV   = 6'b000100,
        ST_APPLY = 6'b001000,
        ST_OUT0  = 6'b010000,
        ST_OUT1  = 6'b100000
    } ctrl_state_t;

    ctrl_state_t state_reg, state_next;

    always_comb begin
        state_next    = state_reg;
        cmd           = '0;
        cmd.sel       = (state_reg == ST_OUT1);
        unique case (state_reg)
            ST_IDLE: begin
                if (s_tvalid) begin
                    cmd.latch  = 1'b1;
                    state_next = ST_CHECK;
                end
            end
            ST_CHECK: begin
                if (sts.need_div) begin
                    cmd.div_start = 1'b1;
                    state_next    = ST_DIV;
                end else begin
                    state_next = ST_APPLY;
                end
            end
            ST_DIV: begin
                if (sts.div_done) state_next = ST_APPLY;
            end
            ST_APPLY: begin
                cmd.apply  = 1'b1;
                state_next = (sts.step_rows != 2'd0) ? ST_OUT0 : ST_IDLE;
            end
            ST_OUT0: begin
                if (m_tready) state_next = sts.two_rows ? ST_OUT1 : ST_IDLE;
            end
            ST_OUT1: begin
                if (m_tready) state_next = ST_IDLE;
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) state_reg <= ST_IDLE;
        else          state_reg <= state_next;
    end

    assign s_tready = (state_reg == ST_IDLE);
    assign m_tvalid = (state_reg == ST_OUT0) || (state_reg == ST_OUT1);
endmodule
`default_nettype wire

// ===== hw/rtl/wpp_dp.sv =====
// Parser datapath: held header state, per-byte step logic and result slots.
`timescale 1ns / 1ps
`default_nettype none
module wpp_dp #(
    parameter int MAX_SAMPLE_BYTES = wpp_pkg::MAX_SAMPLE_BYTES_DEF
) (
    input  wire                                aclk,
    input  wire                                aresetn,
    input  wire                                cfg_wr_en,
    input  wire  [wpp_pkg::STREAM_LEN_W-1:0]   cfg_wr_data,
    input  wire  [7:0]                         in_byte,
    input  wire                                in_last,
    input  wpp_pkg::cmd_t                      cmd,
    output wpp_pkg::sts_t                      sts,
    output wpp_pkg::res_t                      out_row
);
    import wpp_pkg::*;

    localparam logic [16:0] BITS_MAX = 17'(8 * MAX_SAMPLE_BYTES);

    logic [STREAM_LEN_W-1:0] stream_length_reg;
    logic [7:0]  byte_reg;
    logic        last_reg;

    phase_t      phase_reg, phase_next;
    logic [4:0]  fbc_reg, fbc_next;
    logic [63:0] gather_reg, gather_next;
    logic        fs_reg, fs_next;
    logic [31:0] csh_reg, csh_next;
    logic [15:0] ch_reg, ch_next;
    logic [31:0] rate_reg, rate_next;
    logic [31:0] brate_reg, brate_next;
    logic [15:0] align_reg, align_next;
    logic [15:0] bits_reg, bits_next;
    logic [3:0]  sb_reg, sb_next;
    logic [31:0] fl_reg, fl_next;
    logic [15:0] chan_reg, chan_next;
    logic [2:0]  sbn_reg, sbn_next;
    logic [63:0] acc_reg, acc_next;

    res_t        slot0_reg, slot1_reg;
    logic        two_reg;
    res_t        row_a, row0, row1;
    logic        a_v;
    logic [1:0]  n_rows;

    logic [4:0]  cnt;
    logic [31:0] word, id;
    logic [15:0] half;
    logic [32:0] padded;
    logic [32:0] skip_cnt;
    logic [16:0] nb_sum;
    logic [3:0]  nb;
    logic [19:0] nb_ch;
    logic [3:0]  k;
    logic [63:0] acc_new, v;
    logic        fend;
    logic [31:0] fl_dec;

    logic        div_done;
    logic [31:0] div_quo;
    logic [15:0] div_rem;

    wpp_div u_div (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .start     (cmd.div_start),
        .dividend  (word),
        .divisor   (align_reg),
        .done      (div_done),
        .quotient  (div_quo),
        .remainder (div_rem)
    );

    function automatic res_t err_row(input logic [3:0] code);
        res_t r;
        r      = '0;
        r.kind = KIND_ERROR;
        r.err  = code;
        return r;
    endfunction

    function automatic logic [63:0] sign_ext(input logic [63:0] x, input logic [3:0] nbytes);
        logic [63:0] y;
        y = x;
        unique case (nbytes)
            4'd2: if (x[15]) y[63:16] = '1;
            4'd3: if (x[23]) y[63:24] = '1;
            4'd4: if (x[31]) y[63:32] = '1;
            4'd5: if (x[39]) y[63:40] = '1;
            4'd6: if (x[47]) y[63:48] = '1;
            4'd7: if (x[55]) y[63:56] = '1;
            default: y = x;
        endcase
        return y;
    endfunction

    always_comb begin
        cnt         = fbc_reg + 5'd1;
        gather_next = {byte_reg, gather_reg[63:8]};
        word        = gather_next[63:32];
        half        = gather_next[63:48];
        id          = gather_next[31:0];
        padded      = {1'b0, word} + {32'b0, word[0]};
        nb_sum      = {1'b0, half} + 17'd7;
        nb          = nb_sum[6:3];
        nb_ch       = {16'b0, nb} * {4'b0, ch_reg};
        k           = {1'b0, sbn_reg} + 4'd1;
        acc_new     = acc_reg | ({56'b0, byte_reg} << {sbn_reg, 3'b000});
        v           = sign_ext(acc_new, k);
        fend        = ({1'b0, chan_reg} + 17'd1) >= {1'b0, ch_reg};
        fl_dec      = fl_reg - 32'd1;
        skip_cnt    = '0;

        phase_next = phase_reg;
        fbc_next   = fbc_reg;
        fs_next    = fs_reg;
        csh_next   = csh_reg;
        ch_next    = ch_reg;
        rate_next  = rate_reg;
        brate_next = brate_reg;
        align_next = align_reg;
        bits_next  = bits_reg;
        sb_next    = sb_reg;
        fl_next    = fl_reg;
        chan_next  = chan_reg;
        sbn_next   = sbn_reg;
        acc_next   = acc_reg;
        row_a      = '0;
        a_v        = 1'b0;

        sts.need_div = (phase_reg == PH_CHUNK) && (cnt >= 5'd8) && (id == TAG_DATA)
                       && fs_reg && (align_reg != 16'd0);

        unique case (phase_reg)
            PH_RIFF: begin
                fbc_next = cnt;
                if (cnt == 5'd4 && word != TAG_RIFF) begin
                    a_v = 1'b1; row_a = err_row(ERR_RIFF_TAG); phase_next = PH_ERROR;
                end else if (cnt == 5'd8) begin
                    csh_next = word;
                end else if (cnt >= 5'd12) begin
                    if (word != TAG_WAVE) begin
                        a_v = 1'b1; row_a = err_row(ERR_WAVE_TAG); phase_next = PH_ERROR;
                    end else if (({1'b0, csh_reg} + 33'd8) != stream_length_reg) begin
                        a_v = 1'b1; row_a = err_row(ERR_SIZE); phase_next = PH_ERROR;
                    end else begin
                        phase_next = PH_CHUNK;
                        fbc_next   = '0;
                    end
                end
            end
            PH_CHUNK: begin
                fbc_next = cnt;
                if (cnt >= 5'd8) begin
                    csh_next = word;
                    fbc_next = '0;
                    if (id == TAG_FMT) begin
                        phase_next = PH_FMT;
                    end else if (id == TAG_DATA) begin
                        if (!fs_reg) begin
                            a_v = 1'b1; row_a = err_row(ERR_DATA_EARLY); phase_next = PH_ERROR;
                        end else if (align_reg == 16'd0) begin
                            a_v = 1'b1; row_a = err_row(ERR_ZERO_ALIGN); phase_next = PH_ERROR;
                        end else if (div_rem != 16'd0) begin
                            a_v = 1'b1; row_a = err_row(ERR_DATA_SIZE); phase_next = PH_ERROR;
                        end else begin
                            a_v              = 1'b1;
                            row_a.kind       = KIND_FORMAT;
                            row_a.chan_count = ch_reg;
                            row_a.rate       = rate_reg;
                            row_a.byte_rate  = brate_reg;
                            row_a.bits       = bits_reg;
                            row_a.frames     = div_quo;
                            fl_next          = div_quo;
                            chan_next        = '0;
                            sbn_next         = '0;
                            acc_next         = '0;
                            phase_next       = (div_quo != 32'd0) ? PH_SAMPLES : PH_DONE;
                        end
                    end else begin
                        skip_cnt = padded;
                        if (padded == 33'd0) begin
                            phase_next = PH_CHUNK;
                        end else begin
                            csh_next   = 32'(padded - 33'd1);
                            phase_next = PH_SKIP;
                        end
                    end
                end
            end
            PH_FMT: begin
                fbc_next = cnt;
                if (cnt == 5'd2) begin
                    bits_next = half;
                end else if (cnt == 5'd4) begin
                    ch_next = half;
                end else if (cnt == 5'd8) begin
                    rate_next = word;
                end else if (cnt == 5'd12) begin
                    brate_next = word;
                end else if (cnt == 5'd14) begin
                    align_next = half;
                end else if (cnt >= 5'd16) begin
                    bits_next = half;
                    if (bits_reg != 16'd1) begin
                        a_v = 1'b1; row_a = err_row(ERR_NOT_PCM); phase_next = PH_ERROR;
                    end else if (ch_reg == 16'd0) begin
                        a_v = 1'b1; row_a = err_row(ERR_ZERO_CHAN); phase_next = PH_ERROR;
                    end else if (align_reg == 16'd0) begin
                        a_v = 1'b1; row_a = err_row(ERR_ZERO_ALIGN); phase_next = PH_ERROR;
                    end else if (half < 16'd2) begin
                        a_v = 1'b1; row_a = err_row(ERR_BITS_LOW); phase_next = PH_ERROR;
                    end else if ({1'b0, half} > BITS_MAX) begin
                        a_v = 1'b1; row_a = err_row(ERR_BITS_HIGH); phase_next = PH_ERROR;
                    end else if (nb_ch != {4'b0, align_reg}) begin
                        a_v = 1'b1; row_a = err_row(ERR_ALIGN); phase_next = PH_ERROR;
                    end else begin
                        fs_next  = 1'b1;
                        sb_next  = nb;
                        fbc_next = '0;
                        // padded fmt size beyond the 16 body bytes is skipped
                        if (({1'b0, csh_reg} + {32'b0, csh_reg[0]}) > 33'd16)
                            skip_cnt = {1'b0, csh_reg} + {32'b0, csh_reg[0]} - 33'd16;
                        if (skip_cnt == 33'd0) begin
                            phase_next = PH_CHUNK;
                        end else begin
                            csh_next   = 32'(skip_cnt - 33'd1);
                            phase_next = PH_SKIP;
                        end
                    end
                end
            end
            PH_SKIP: begin
                if (csh_reg == 32'd0) begin
                    phase_next = PH_CHUNK;
                    fbc_next   = '0;
                end else begin
                    csh_next = csh_reg - 32'd1;
                end
            end
            PH_SAMPLES: begin
                acc_next = acc_new;
                if (k >= sb_reg || k >= 4'd8) begin
                    a_v          = 1'b1;
                    row_a.kind   = KIND_SAMPLE;
                    row_a.sample = v;
                    row_a.chan   = chan_reg;
                    row_a.fend   = fend;
                    acc_next     = '0;
                    sbn_next     = '0;
                    if (fend) begin
                        chan_next = '0;
                        fl_next   = fl_dec;
                        if (fl_dec == 32'd0) phase_next = PH_DONE;
                    end else begin
                        chan_next = chan_reg + 16'd1;
                    end
                end else begin
                    sbn_next = k[2:0];
                end
            end
            PH_DONE, PH_ERROR: begin
            end
            default: begin
            end
        endcase

        row0   = row_a;
        row1   = '0;
        n_rows = a_v ? 2'd1 : 2'd0;
        if (last_reg) begin
            if (phase_next != PH_DONE && phase_next != PH_ERROR) begin
                if (a_v) begin
                    row1   = err_row(ERR_EARLY_END);
                    n_rows = 2'd2;
                end else begin
                    row0   = err_row(ERR_EARLY_END);
                    n_rows = 2'd1;
                end
            end
            phase_next  = PH_RIFF;
            fbc_next    = '0;
            gather_next = '0;
            fs_next     = 1'b0;
            csh_next    = '0;
            ch_next     = '0;
            rate_next   = '0;
            brate_next  = '0;
            align_next  = '0;
            bits_next   = '0;
            sb_next     = '0;
            fl_next     = '0;
            chan_next   = '0;
            sbn_next    = '0;
            acc_next    = '0;
        end
        if (n_rows == 2'd2) row1.run_end = 1'b1;
        else                row0.run_end = 1'b1;

        sts.div_done  = div_done;
        sts.step_rows = n_rows;
        sts.two_rows  = two_reg;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            stream_length_reg <= '0;
            phase_reg  <= PH_RIFF;
            fbc_reg    <= '0;
            gather_reg <= '0;
            fs_reg     <= 1'b0;
            csh_reg    <= '0;
            ch_reg     <= '0;
            rate_reg   <= '0;
            brate_reg  <= '0;
            align_reg  <= '0;
            bits_reg   <= '0;
            sb_reg     <= '0;
            fl_reg     <= '0;
            chan_reg   <= '0;
            sbn_reg    <= '0;
            acc_reg    <= '0;
            two_reg    <= 1'b0;
        end else begin
            if (cfg_wr_en) stream_length_reg <= cfg_wr_data;
            if (cmd.apply) begin
                phase_reg  <= phase_next;
                fbc_reg    <= fbc_next;
                gather_reg <= gather_next;
                fs_reg     <= fs_next;
                csh_reg    <= csh_next;
                ch_reg     <= ch_next;
                rate_reg   <= rate_next;
                brate_reg  <= brate_next;
                align_reg  <= align_next;
                bits_reg   <= bits_next;
                sb_reg     <= sb_next;
                fl_reg     <= fl_next;
                chan_reg   <= chan_next;
                sbn_reg    <= sbn_next;
                acc_reg    <= acc_next;
                two_reg    <= (n_rows == 2'd2);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.latch) begin
            byte_reg <= in_byte;
            last_reg <= in_last;
        end
        if (cmd.apply) begin
            slot0_reg <= row0;
            slot1_reg <= row1;
        end
    end

    assign out_row = cmd.sel ? slot1_reg : slot0_reg;
endmodule
`default_nettype wire

// ===== hw/rtl/wav_pcm_stream_parser_unit.sv =====
// Top level of the RIFF WAV PCM stream parser.
`timescale 1ns / 1ps
`default_nettype none
// Feed a WAV file one byte per request on the s_ channel, tlast on its final
// byte, after writing the total file length through cfg_wr_en/cfg_wr_data
// while the block is idle. The parser checks the RIFF/WAVE header, walks the
// chunks, validates the fmt body and at the data chunk sends one format
// report, then one request per sample (little-endian, sign-extended unless one
// byte wide) with its channel and a frame-end flag. Errors send one error
// request and the parser ignores bytes until tlast, which always restarts it.
// Sequence: each byte passes through the accept, check and apply states, then
// its result requests are delivered one at a time, at most two, each held until
// m_tready; the data chunk header also waits on a bit-serial 32/16 divider for the frame count.
module wav_pcm_stream_parser_unit #(
    parameter int MAX_SAMPLE_BYTES = wpp_pkg::MAX_SAMPLE_BYTES_DEF
) (
    input  wire                               aclk,
    input  wire                               aresetn,
    input  wire                               cfg_wr_en,
    input  wire  [wpp_pkg::STREAM_LEN_W-1:0]  cfg_wr_data,  // stream_length
    input  wire                               s_tvalid,
    output logic                              s_tready,
    input  wire  [7:0]                        s_tdata,      // [7:0] stream_byte
    input  wire                               s_tlast,      // stream_last
    output logic                              m_tvalid,
    input  wire                               m_tready,
    // [63:0] sample_value, [79:64] channel_index, [80] frame_end,
    // [84:81] error_code, [100:85] channel_count, [132:101] rate_samples,
    // [164:133] rate_bytes, [180:165] bits_valid, [212:181] frame_total,
    // [215:213] zero
    output logic [wpp_pkg::TDATA_W-1:0]       m_tdata,
    output logic [1:0]                        m_tuser,      // [1:0] result_kind
    output logic                              m_tlast       // run_end
);
    import wpp_pkg::*;

    cmd_t cmd;
    sts_t sts;
    res_t row;

    // Sequencer: owns both handshakes and the divide wait.
    wpp_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .sts      (sts),
        .cmd      (cmd)
    );

    // Datapath: header state, step logic and the two result slots.
    wpp_dp #(
        .MAX_SAMPLE_BYTES (MAX_SAMPLE_BYTES)
    ) u_dp (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .in_byte     (s_tdata),
        .in_last     (s_tlast),
        .cmd         (cmd),
        .sts         (sts),
        .out_row     (row)
    );

    // Pack the selected slot onto the result channel.
    assign m_tdata = {3'b000, row.frames, row.bits, row.byte_rate, row.rate,
                      row.chan_count, row.err, row.fend, row.chan, row.sample};
    assign m_tuser = row.kind;
    assign m_tlast = row.run_end;
endmodule
`default_nettype wire

// ===== hw/rtl/wpp_checker.sv =====
// Port-level checker for the parser top level, with its bind.
`timescale 1ns / 1ps
`default_nettype none
module wpp_checker (
    input wire                              aclk,
    input wire                              aresetn,
    input wire                              s_tready,
    input wire                              m_tvalid,
    input wire                              m_tready,
    input wire [wpp_pkg::TDATA_W-1:0]       m_tdata,
    input wire [1:0]                        m_tuser,
    input wire                              m_tlast
);
    import wpp_pkg::*;

    // Hold a stalled result request.
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid)
        else $error("result request dropped while stalled");

    // No new byte while a result is still pending.
    a_excl: assert property (@(posedge aclk) disable iff (!aresetn)
        !(m_tvalid && s_tready))
        else $error("byte taken while result pending");

    a_kind: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (m_tuser == KIND_SAMPLE || m_tuser == KIND_FORMAT
                      || m_tuser == KIND_ERROR))
        else $error("undefined result kind");

    // Early end is always the final result of its byte.
    a_early: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser == KIND_ERROR && m_tdata[84:81] == ERR_EARLY_END
        |-> m_tlast)
        else $error("early end error not last of its run");
endmodule

bind wav_pcm_stream_parser_unit wpp_checker u_wpp_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast)
);
`default_nettype wire
